FILE: rtl/sdh_pkg.sv
// Package for the SD card SPI-mode host engine: codes, descriptor and result types.
// No dependencies; used by every module of the block.
`default_nettype none

package sdh_pkg;

  localparam int BLOCK_BYTES       = 512;
  localparam int CLOCK_TRAIN_BYTES = 10;
  localparam int QUEUE_DEPTH       = 4;

  // action codes
  localparam logic [2:0] ACT_INIT  = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_REPLY = 3'd3;
  localparam logic [2:0] ACT_WBYTE = 3'd4;
  localparam logic [2:0] ACT_TICK  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ERR       = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;
  localparam logic [1:0] ST_PARAM     = 2'd3;

  // sequencer phases
  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_CMD0     = 5'd1;
  localparam logic [4:0] PH_CMD8     = 5'd2;
  localparam logic [4:0] PH_ACMD41   = 5'd3;
  localparam logic [4:0] PH_CMD58    = 5'd4;
  localparam logic [4:0] PH_OCR      = 5'd5;
  localparam logic [4:0] PH_RD_CMD   = 5'd6;
  localparam logic [4:0] PH_RD_TOKEN = 5'd7;
  localparam logic [4:0] PH_RD_DATA  = 5'd8;
  localparam logic [4:0] PH_WR_CMD   = 5'd9;
  localparam logic [4:0] PH_WR_DATA  = 5'd10;
  localparam logic [4:0] PH_WR_RESP  = 5'd11;
  localparam logic [4:0] PH_WR_BUSY  = 5'd12;

  // card command indexes
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_READ_BLK  = 6'd17;
  localparam logic [5:0] CMD_WRITE_BLK = 6'd24;
  localparam logic [5:0] CMD_APP_OP    = 6'd41;
  localparam logic [5:0] CMD_APP_CMD   = 6'd55;
  localparam logic [5:0] CMD_READ_OCR  = 6'd58;

  localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
  localparam logic [7:0]  CRC_CMD0    = 8'h95;
  localparam logic [7:0]  CRC_CMD8    = 8'h87;
  localparam logic [7:0]  CRC_DUMMY   = 8'h01;
  localparam logic [7:0]  TOKEN_START = 8'hFE;
  localparam logic [7:0]  IDLE_BYTE   = 8'hFF;
  localparam logic [4:0]  DRESP_MASK  = 5'h1F;
  localparam logic [4:0]  DRESP_OK    = 5'h05;

  // register addresses (word index)
  localparam logic [1:0] REG_RESP_TO  = 2'd0;
  localparam logic [1:0] REG_TOKEN_TO = 2'd1;
  localparam logic [1:0] REG_BUSY_TO  = 2'd2;
  localparam logic [1:0] REG_RETRY    = 2'd3;

  typedef struct packed {
    logic [9:0]  resp_to;
    logic [9:0]  token_to;
    logic [9:0]  busy_to;
    logic [11:0] retry_limit;
  } sdh_cfg_t;

  // One descriptor covers all byte exchanges caused by one input item, emitted
  // in field order: lead byte, clock train, plain bytes, tail, deselect,
  // command frame, done.
  typedef struct packed {
    logic        lead_en;
    logic [7:0]  lead_byte;
    logic        lead_rep;
    logic        lead_dw;
    logic        lead_rv;
    logic [7:0]  lead_rd;
    logic        train;
    logic [2:0]  nplain;
    logic        tail_en;
    logic        tail_fe;
    logic        desel;
    logic        cmd_en;
    logic [5:0]  cmd_idx;
    logic [31:0] cmd_arg;
    logic        done_en;
    logic [1:0]  st;
    logic        ready;
  } sdh_desc_t;

  typedef struct packed {
    logic [7:0] mosi;
    logic       sel;
    logic       rep;
    logic       dw;
    logic       rv;
    logic [7:0] rd;
    logic       done;
    logic [1:0] st;
    logic       ready;
    logic       last;
  } sdh_res_t;

endpackage

`default_nettype wire

FILE: rtl/sd_card_spi_host_engine.sv
// SD card SPI-mode host engine, top level: config registers, front end, queue, back end.
// Latency: the first result of an item passes through the descriptor queue and the output register.
// Throughput: an item is taken every cycle while the 4-entry descriptor queue has room;
// results leave at one per cycle while the consumer pops, and an item makes 0..18 results.
// Reset: synchronous active-low; state idle, card not ready, registers 1/100/500/4095.
// Depends on sdh_pkg, sdh_front, sdh_queue, sdh_back.
`default_nettype none

module sd_card_spi_host_engine #(
  parameter int CLOCK_TRAIN_BYTES = sdh_pkg::CLOCK_TRAIN_BYTES,
  parameter int QUEUE_DEPTH       = sdh_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  in_action,
  input  wire logic [7:0]  in_drive,
  input  wire logic [31:0] in_sector,
  input  wire logic [7:0]  in_sector_count,
  input  wire logic [7:0]  in_miso_byte,
  input  wire logic [7:0]  in_write_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_mosi_byte,
  output logic             out_select_low,
  output logic             out_reply_wanted,
  output logic             out_data_wanted,
  output logic             out_read_valid,
  output logic [7:0]       out_read_data,
  output logic             out_done_res,
  output logic [1:0]       out_status,
  output logic             out_ready_res,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sdh_pkg::*;

  sdh_cfg_t  cfg_r;
  sdh_desc_t q_wdata, q_head;
  sdh_res_t  res;
  logic      q_wr, q_rd, q_full, q_nonempty, out_valid, accept, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.resp_to     <= 10'd1;
      cfg_r.token_to    <= 10'd100;
      cfg_r.busy_to     <= 10'd500;
      cfg_r.retry_limit <= 12'd4095;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RESP_TO:  cfg_r.resp_to     <= pwdata[9:0];
        REG_TOKEN_TO: cfg_r.token_to    <= pwdata[9:0];
        REG_BUSY_TO:  cfg_r.busy_to     <= pwdata[9:0];
        REG_RETRY:    cfg_r.retry_limit <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RESP_TO:  prdata = {22'd0, cfg_r.resp_to};
      REG_TOKEN_TO: prdata = {22'd0, cfg_r.token_to};
      REG_BUSY_TO:  prdata = {22'd0, cfg_r.busy_to};
      REG_RETRY:    prdata = {20'd0, cfg_r.retry_limit};
      default:      prdata = '0;
    endcase
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  sdh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .action       (in_action),
    .drive        (in_drive),
    .sector       (in_sector),
    .sector_count (in_sector_count),
    .miso_byte    (in_miso_byte),
    .write_byte   (in_write_byte),
    .cfg          (cfg_r),
    .q_wr         (q_wr),
    .q_data       (q_wdata)
  );

  sdh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wr_data  (q_wdata),
    .rd       (q_rd),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  sdh_back #(.CLOCK_TRAIN_BYTES(CLOCK_TRAIN_BYTES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .head       (q_head),
    .q_rd       (q_rd),
    .pop        (pop),
    .out_valid  (out_valid),
    .res        (res)
  );

  assign empty            = !out_valid;
  assign out_mosi_byte    = res.mosi;
  assign out_select_low   = res.sel;
  assign out_reply_wanted = res.rep;
  assign out_data_wanted  = res.dw;
  assign out_read_valid   = res.rv;
  assign out_read_data    = res.rd;
  assign out_done_res     = res.done;
  assign out_status       = res.st;
  assign out_ready_res    = res.ready;
  assign out_last         = res.last;

endmodule

`default_nettype wire

FILE: rtl/sdh_front.sv
// Front end: takes input items, runs the card protocol state and emits at most one
// transaction descriptor per item. Depends on sdh_pkg.
`default_nettype none

module sdh_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [2:0]       action,
  input  wire logic [7:0]       drive,
  input  wire logic [31:0]      sector,
  input  wire logic [7:0]       sector_count,
  input  wire logic [7:0]       miso_byte,
  input  wire logic [7:0]       write_byte,
  input  wire sdh_pkg::sdh_cfg_t cfg,
  output logic                  q_wr,
  output sdh_pkg::sdh_desc_t    q_data
);
  import sdh_pkg::*;

  logic [4:0]  phase_r, phase_nxt;
  logic        ready_r, ready_nxt;
  logic        blk_r, blk_nxt;
  logic [11:0] retry_r, retry_nxt;
  logic [9:0]  bidx_r, bidx_nxt;
  logic [9:0]  el_r, el_nxt;
  logic [31:0] sec_r, sec_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        app_r, app_nxt;

  sdh_desc_t d;
  logic      fin, fsec, fsec_wr, a41, a41_ok, start41, r1phase;
  logic [1:0] fin_st;
  logic [9:0] bi;

  function automatic logic [31:0] card_addr(input logic blk, input logic [31:0] s);
    card_addr = blk ? s : {s[22:0], 9'b0};
  endfunction

  always_comb begin
    phase_nxt = phase_r; ready_nxt = ready_r; blk_nxt = blk_r; retry_nxt = retry_r;
    bidx_nxt = bidx_r; el_nxt = el_r; sec_nxt = sec_r; left_nxt = left_r; app_nxt = app_r;
    d = '0;
    d.lead_byte = IDLE_BYTE;
    fin = 1'b0; fin_st = ST_OK; fsec = 1'b0; fsec_wr = 1'b0;
    a41 = 1'b0; a41_ok = 1'b0; start41 = 1'b0;
    bi = bidx_r + 10'd1;
    r1phase = (phase_r == PH_CMD0) || (phase_r == PH_CMD8) || (phase_r == PH_ACMD41) ||
              (phase_r == PH_CMD58) || (phase_r == PH_RD_CMD) || (phase_r == PH_WR_CMD);
    if (accept) begin
      unique case (action)
        ACT_INIT: begin
          if (phase_r == PH_IDLE) begin
            if (drive != 8'd0) begin
              d.done_en = 1'b1; d.st = ST_PARAM;
            end else begin
              ready_nxt = 1'b0; app_nxt = 1'b0; retry_nxt = cfg.retry_limit;
              d.train = 1'b1;
              d.cmd_en = 1'b1; d.cmd_idx = CMD_GO_IDLE; d.cmd_arg = '0;
              phase_nxt = PH_CMD0;
            end
          end
        end
        ACT_READ, ACT_WRITE: begin
          if (phase_r == PH_IDLE) begin
            if (drive != 8'd0 || sector_count == 8'd0) begin
              d.done_en = 1'b1; d.st = ST_PARAM;
            end else if (!ready_r) begin
              d.done_en = 1'b1; d.st = ST_NOT_READY;
            end else begin
              sec_nxt = sector; left_nxt = sector_count;
              d.cmd_en = 1'b1;
              d.cmd_idx = (action == ACT_WRITE) ? CMD_WRITE_BLK : CMD_READ_BLK;
              d.cmd_arg = card_addr(blk_r, sector);
              phase_nxt = (action == ACT_WRITE) ? PH_WR_CMD : PH_RD_CMD;
            end
          end
        end
        ACT_REPLY: begin
          if (r1phase && miso_byte[7] && el_r < cfg.resp_to) begin
            d.lead_en = 1'b1; d.lead_rep = 1'b1;
          end else begin
            unique case (phase_r)
              PH_CMD0: begin
                if (miso_byte == 8'h01) begin
                  d.cmd_en = 1'b1; d.cmd_idx = CMD_IF_COND; d.cmd_arg = ARG_IF_COND;
                  phase_nxt = PH_CMD8;
                end else begin
                  retry_nxt = retry_r - 12'd1;
                  if (retry_nxt == 12'd0) begin
                    fin = 1'b1; fin_st = ST_ERR;
                  end else begin
                    d.cmd_en = 1'b1; d.cmd_idx = CMD_GO_IDLE; d.cmd_arg = '0;
                  end
                end
              end
              PH_CMD8: begin
                if (!miso_byte[2]) d.nplain = 3'd4;   // skip the R7 tail
                retry_nxt = cfg.retry_limit;
                start41 = 1'b1;
              end
              PH_ACMD41: begin
                if (app_r) begin
                  app_nxt = 1'b0;
                  if (miso_byte > 8'd1) begin
                    a41 = 1'b1;
                  end else begin
                    d.cmd_en = 1'b1; d.cmd_idx = CMD_APP_OP; d.cmd_arg = ARG_HCS;
                  end
                end else begin
                  a41 = 1'b1; a41_ok = (miso_byte == 8'd0);
                end
              end
              PH_CMD58: begin
                if (miso_byte != 8'd0) begin
                  fin = 1'b1; fin_st = ST_ERR;
                end else begin
                  d.lead_en = 1'b1; d.lead_rep = 1'b1; d.nplain = 3'd3;
                  phase_nxt = PH_OCR;
                end
              end
              PH_OCR: begin
                blk_nxt = miso_byte[6];
                ready_nxt = 1'b1;
                fin = 1'b1; fin_st = ST_OK;
              end
              PH_RD_CMD: begin
                if (miso_byte != 8'd0) begin
                  fin = 1'b1; fin_st = ST_ERR;
                end else begin
                  d.lead_en = 1'b1; d.lead_rep = 1'b1;
                  el_nxt = '0;
                  phase_nxt = PH_RD_TOKEN;
                end
              end
              PH_RD_TOKEN: begin
                if (miso_byte == IDLE_BYTE && el_r < cfg.token_to) begin
                  d.lead_en = 1'b1; d.lead_rep = 1'b1;
                end else if (miso_byte != TOKEN_START) begin
                  fin = 1'b1; fin_st = ST_ERR;
                end else begin
                  bidx_nxt = '0;
                  d.lead_en = 1'b1; d.lead_rep = 1'b1;
                  phase_nxt = PH_RD_DATA;
                end
              end
              PH_RD_DATA: begin
                bidx_nxt = bi;
                d.lead_en = 1'b1; d.lead_rv = 1'b1; d.lead_rd = miso_byte;
                if (bi < 10'(BLOCK_BYTES)) begin
                  d.lead_rep = 1'b1;
                end else begin
                  d.nplain = 3'd1;
                  fsec = 1'b1; fsec_wr = 1'b0;
                end
              end
              PH_WR_CMD: begin
                if (miso_byte != 8'd0) begin
                  fin = 1'b1; fin_st = ST_ERR;
                end else begin
                  d.lead_en = 1'b1;
                  d.tail_en = 1'b1; d.tail_fe = 1'b1;
                  bidx_nxt = '0;
                  phase_nxt = PH_WR_DATA;
                end
              end
              PH_WR_RESP: begin
                if ((miso_byte[4:0] & DRESP_MASK) != DRESP_OK) begin
                  fin = 1'b1; fin_st = ST_ERR;
                end else begin
                  d.lead_en = 1'b1; d.lead_rep = 1'b1;
                  el_nxt = '0;
                  phase_nxt = PH_WR_BUSY;
                end
              end
              PH_WR_BUSY: begin
                if (miso_byte == 8'd0) begin
                  if (el_r >= cfg.busy_to) begin
                    fin = 1'b1; fin_st = ST_ERR;
                  end else begin
                    d.lead_en = 1'b1; d.lead_rep = 1'b1;
                  end
                end else begin
                  fsec = 1'b1; fsec_wr = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ACT_WBYTE: begin
          if (phase_r == PH_WR_DATA) begin
            bidx_nxt = bi;
            d.lead_en = 1'b1; d.lead_byte = write_byte;
            if (bi < 10'(BLOCK_BYTES)) begin
              d.lead_dw = 1'b1;
            end else begin
              d.nplain = 3'd2;
              d.tail_en = 1'b1; d.tail_fe = 1'b0;
              phase_nxt = PH_WR_RESP;
            end
          end
        end
        ACT_TICK: begin
          if (el_r != 10'h3FF) el_nxt = el_r + 10'd1;
        end
        default: ;
      endcase
    end

    if (a41) begin
      if (a41_ok) begin
        d.cmd_en = 1'b1; d.cmd_idx = CMD_READ_OCR; d.cmd_arg = '0;
        phase_nxt = PH_CMD58;
      end else begin
        retry_nxt = retry_r - 12'd1;
        if (retry_nxt == 12'd0) begin
          fin = 1'b1; fin_st = ST_ERR;
        end else begin
          start41 = 1'b1;
        end
      end
    end
    if (start41) begin
      app_nxt = 1'b1;
      d.cmd_en = 1'b1; d.cmd_idx = CMD_APP_CMD; d.cmd_arg = '0;
      phase_nxt = PH_ACMD41;
    end
    if (fin) begin
      d.desel = 1'b1; d.done_en = 1'b1; d.st = fin_st;
      phase_nxt = PH_IDLE; app_nxt = 1'b0;
    end
    if (fsec) begin
      d.desel = 1'b1;
      sec_nxt = sec_r + 32'd1;
      left_nxt = left_r - 8'd1;
      if (left_nxt == 8'd0) begin
        d.done_en = 1'b1; d.st = ST_OK;
        phase_nxt = PH_IDLE;
      end else begin
        d.cmd_en = 1'b1;
        d.cmd_idx = fsec_wr ? CMD_WRITE_BLK : CMD_READ_BLK;
        d.cmd_arg = card_addr(blk_r, sec_nxt);
        phase_nxt = fsec_wr ? PH_WR_CMD : PH_RD_CMD;
      end
    end
    if (d.cmd_en) el_nxt = '0;
    d.ready = ready_nxt;
  end

  assign q_data = d;
  assign q_wr   = accept && (d.lead_en || d.train || d.nplain != 3'd0 || d.tail_en ||
                             d.desel || d.cmd_en || d.done_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; ready_r <= 1'b0; blk_r <= 1'b0; retry_r <= '0;
      bidx_r <= '0; el_r <= '0; sec_r <= '0; left_r <= '0; app_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; ready_r <= ready_nxt; blk_r <= blk_nxt; retry_r <= retry_nxt;
      bidx_r <= bidx_nxt; el_r <= el_nxt; sec_r <= sec_nxt; left_r <= left_nxt;
      app_r <= app_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sdh_queue.sv
// Short descriptor queue between front and back end, flop storage.
// Depends on sdh_pkg.
`default_nettype none

module sdh_queue #(
  parameter int DEPTH = sdh_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr,
  input  wire sdh_pkg::sdh_desc_t wr_data,
  input  wire logic               rd,
  output logic                    full,
  output logic                    nonempty,
  output sdh_pkg::sdh_desc_t      head
);
  import sdh_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sdh_desc_t       mem_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rp_r];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= bump(wp_r);
      if (rd) rp_r <= bump(rp_r);
      if (wr && !rd) cnt_r <= cnt_r + CW'(1);
      else if (rd && !wr) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sdh_back.sv
// Back end: expands queued descriptors into byte transactions in the output register,
// one per cycle while that register is empty or being popped. Depends on sdh_pkg.
`default_nettype none

module sdh_back #(
  parameter int CLOCK_TRAIN_BYTES = sdh_pkg::CLOCK_TRAIN_BYTES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_nonempty,
  input  wire sdh_pkg::sdh_desc_t head,
  output logic                    q_rd,
  input  wire logic               pop,
  output logic                    out_valid,
  output sdh_pkg::sdh_res_t       res
);
  import sdh_pkg::*;

  localparam logic [2:0] SEG_LEAD  = 3'd0;
  localparam logic [2:0] SEG_TRAIN = 3'd1;
  localparam logic [2:0] SEG_PLAIN = 3'd2;
  localparam logic [2:0] SEG_TAIL  = 3'd3;
  localparam logic [2:0] SEG_DESEL = 3'd4;
  localparam logic [2:0] SEG_CMD   = 3'd5;
  localparam logic [2:0] SEG_DONE  = 3'd6;
  localparam logic [2:0] SEG_NONE  = 3'd7;

  logic [2:0] seg_r;
  logic [4:0] cnt_r;
  logic       valid_r;
  sdh_res_t   out_r;

  logic [2:0] cur, nxt;
  logic [4:0] len;
  logic       at_end, is_last, load;
  sdh_res_t   r;
  logic [7:0] crc;

  function automatic logic seg_en(input sdh_desc_t dd, input logic [2:0] s);
    logic e;
    case (s)
      SEG_LEAD:  e = dd.lead_en;
      SEG_TRAIN: e = dd.train;
      SEG_PLAIN: e = (dd.nplain != 3'd0);
      SEG_TAIL:  e = dd.tail_en;
      SEG_DESEL: e = dd.desel;
      SEG_CMD:   e = dd.cmd_en;
      SEG_DONE:  e = dd.done_en;
      default:   e = 1'b0;
    endcase
    seg_en = e;
  endfunction

  function automatic logic [2:0] first_seg(input sdh_desc_t dd, input logic [2:0] from);
    logic [2:0] f;
    f = SEG_NONE;
    for (int i = 6; i >= 0; i--) begin
      if (3'(i) >= from && seg_en(dd, 3'(i))) f = 3'(i);
    end
    first_seg = f;
  endfunction

  always_comb begin
    cur = first_seg(head, seg_r);
    nxt = (cur >= SEG_DONE) ? SEG_NONE : first_seg(head, cur + 3'd1);
    case (cur)
      SEG_TRAIN: len = 5'(CLOCK_TRAIN_BYTES);
      SEG_PLAIN: len = {2'b0, head.nplain};
      SEG_CMD:   len = 5'd8;
      default:   len = 5'd1;
    endcase
    at_end  = (cnt_r + 5'd1 == len);
    is_last = at_end && (nxt == SEG_NONE);

    if (head.cmd_idx == CMD_GO_IDLE)      crc = CRC_CMD0;
    else if (head.cmd_idx == CMD_IF_COND) crc = CRC_CMD8;
    else                                  crc = CRC_DUMMY;

    r = '0;
    r.mosi  = IDLE_BYTE;
    r.ready = head.ready;
    r.last  = is_last;
    case (cur)
      SEG_LEAD: begin
        r.mosi = head.lead_byte; r.sel = 1'b1; r.rep = head.lead_rep;
        r.dw = head.lead_dw; r.rv = head.lead_rv; r.rd = head.lead_rd;
      end
      SEG_PLAIN: r.sel = 1'b1;
      SEG_TAIL: begin
        r.sel = 1'b1;
        if (head.tail_fe) begin
          r.mosi = TOKEN_START; r.dw = 1'b1;
        end else begin
          r.rep = 1'b1;
        end
      end
      SEG_CMD: begin
        r.sel = 1'b1;
        case (cnt_r[2:0])
          3'd1:    r.mosi = {2'b01, head.cmd_idx};
          3'd2:    r.mosi = head.cmd_arg[31:24];
          3'd3:    r.mosi = head.cmd_arg[23:16];
          3'd4:    r.mosi = head.cmd_arg[15:8];
          3'd5:    r.mosi = head.cmd_arg[7:0];
          3'd6:    r.mosi = crc;
          3'd7:    r.rep  = 1'b1;
          default: r.mosi = IDLE_BYTE;
        endcase
      end
      SEG_DONE: begin
        r.done = 1'b1; r.st = head.st;
      end
      default: ;  // clock train and deselect: idle byte, select high
    endcase
  end

  assign load = q_nonempty && (!valid_r || pop);
  assign q_rd = load && is_last;

  always_ff @(posedge clk) begin
    if (load) out_r <= r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0; seg_r <= SEG_LEAD; cnt_r <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        if (is_last) begin
          seg_r <= SEG_LEAD; cnt_r <= '0;
        end else if (at_end) begin
          seg_r <= nxt; cnt_r <= '0;
        end else begin
          seg_r <= cur; cnt_r <= cnt_r + 5'd1;
        end
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = valid_r;
  assign res       = out_r;

endmodule

`default_nettype wire
